### rtl/cosine_weighted_dot_accumulate_defines.svh
// Assertion macros for the cosine weighted dot accumulate checker.
`ifndef COSINE_WEIGHTED_DOT_ACCUMULATE_DEFINES_SVH
`define COSINE_WEIGHTED_DOT_ACCUMULATE_DEFINES_SVH

// Same-cycle implication, off while reset is asserted.
`define CWDA_ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, off while reset is asserted.
`define CWDA_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

// Condition that must hold in the cycle after reset is sampled low.
`define CWDA_ASSERT_AFTER_RESET(label, clk, rst_n, cons, msg) \
    label: assert property (@(posedge clk) !(rst_n) |=> (cons)) \
        else $error(msg);

`endif

### rtl/cwda_pkg.sv
// Shared types, constants and helper functions for the cosine weighted dot accumulate block.
`timescale 1ns / 1ps
`default_nettype none

package cwda_pkg;

    localparam int COSINE_STAGES_DEFAULT = 16;
    localparam int ATAN_ENTRIES          = 24;

    // CORDIC datapath: signed Q2.30 plus guard bits
    localparam int CORDIC_W = 34;

    localparam logic signed [CORDIC_W-1:0] PI_Q30          = 34'sd3373259426;
    localparam logic signed [CORDIC_W-1:0] HALF_PI_Q30     = 34'sd1686629713;
    localparam logic signed [CORDIC_W-1:0] CORDIC_GAIN_Q30 = 34'sd652032874;
    localparam logic signed [CORDIC_W-1:0] ROUND_BIAS      = 34'sd16384;

    localparam int SUM_W  = 48;
    localparam int PROD_W = 33;

    localparam logic signed [SUM_W-1:0] SUM_MAX = {1'b0, {(SUM_W-1){1'b1}}};
    localparam logic signed [SUM_W-1:0] SUM_MIN = {1'b1, {(SUM_W-1){1'b0}}};

    localparam int QUEUE_DEPTH = 4;

    typedef struct packed {
        logic [15:0]              matrix_element;
        logic [14:0]              angle;
        logic signed [SUM_W-1:0]  prior_sum;
        logic                     last_element;
    } cwda_in_t;

    typedef struct packed {
        logic signed [SUM_W-1:0]  new_sum;
        logic                     saturated;
    } cwda_out_t;

    // One weighted product on its way from the front end to the accumulator
    typedef struct packed {
        logic signed [PROD_W-1:0] product;
        logic signed [SUM_W-1:0]  prior_sum;
        logic                     last_element;
    } cwda_prod_t;

    typedef struct packed {
        logic full;
        logic empty;
    } cwda_q_status_t;

    typedef struct packed {
        logic signed [SUM_W-1:0]  value;
        logic                     clipped;
    } cwda_sat_t;

    function automatic logic signed [CORDIC_W-1:0] atan_q30(input int idx);
        logic signed [CORDIC_W-1:0] r;
        case (idx)
            0:       r = 34'sd843314857;
            1:       r = 34'sd497837829;
            2:       r = 34'sd263043836;
            3:       r = 34'sd133525158;
            4:       r = 34'sd67021686;
            5:       r = 34'sd33543515;
            6:       r = 34'sd16775850;
            7:       r = 34'sd8388437;
            8:       r = 34'sd4194282;
            9:       r = 34'sd2097149;
            10:      r = 34'sd1048576;
            11:      r = 34'sd524288;
            12:      r = 34'sd262144;
            13:      r = 34'sd131072;
            14:      r = 34'sd65536;
            15:      r = 34'sd32768;
            16:      r = 34'sd16384;
            17:      r = 34'sd8192;
            18:      r = 34'sd4096;
            19:      r = 34'sd2048;
            20:      r = 34'sd1024;
            21:      r = 34'sd512;
            22:      r = 34'sd256;
            23:      r = 34'sd128;
            default: r = '0;
        endcase
        return r;
    endfunction

    // Clip a 49-bit sum to the 48-bit range
    function automatic cwda_sat_t sat48(input logic signed [SUM_W:0] sum);
        cwda_sat_t r;
        if (sum[SUM_W] != sum[SUM_W-1]) begin
            r.value   = sum[SUM_W] ? SUM_MIN : SUM_MAX;
            r.clipped = 1'b1;
        end else begin
            r.value   = sum[SUM_W-1:0];
            r.clipped = 1'b0;
        end
        return r;
    endfunction

endpackage

`default_nettype wire

### rtl/cwda_queue.sv
// Small request queue between the cosine front end and the accumulator.
`timescale 1ns / 1ps
`default_nettype none

module cwda_queue (
    input  wire logic                     aclk,
    input  wire logic                     aresetn,
    input  wire logic                     push_valid,
    input  wire cwda_pkg::cwda_prod_t     push_data,
    input  wire logic                     pop,
    output cwda_pkg::cwda_prod_t          head_data,
    output cwda_pkg::cwda_q_status_t      status
);

    localparam int DEPTH = cwda_pkg::QUEUE_DEPTH;
    localparam int AW    = $clog2(DEPTH);

    cwda_pkg::cwda_prod_t mem_reg [0:DEPTH-1];
    logic [AW-1:0]        wr_ptr_reg;
    logic [AW-1:0]        rd_ptr_reg;
    logic [AW:0]          count_reg;
    logic [AW:0]          count_next;
    logic                 do_push;
    logic                 do_pop;

    assign status.full  = (count_reg == (AW+1)'(DEPTH));
    assign status.empty = (count_reg == '0);
    assign do_push      = push_valid && !status.full;
    assign do_pop       = pop && !status.empty;
    assign head_data    = mem_reg[rd_ptr_reg];

    always_comb begin
        count_next = count_reg;
        if (do_push && !do_pop) begin
            count_next = count_reg + (AW+1)'(1);
        end else if (do_pop && !do_push) begin
            count_next = count_reg - (AW+1)'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (do_push) begin
                wr_ptr_reg <= wr_ptr_reg + AW'(1);
            end
            if (do_pop) begin
                rd_ptr_reg <= rd_ptr_reg + AW'(1);
            end
            count_reg <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

`default_nettype wire

### rtl/cwda_front.sv
// Front end: angle fold, pipelined CORDIC cosine, rounding and weight multiply.
`timescale 1ns / 1ps
`default_nettype none

module cwda_front #(
    parameter int STAGES = cwda_pkg::COSINE_STAGES_DEFAULT
) (
    input  wire logic                     aclk,
    input  wire logic                     aresetn,
    input  wire logic                     s_valid,
    output logic                          s_ready,
    input  wire cwda_pkg::cwda_in_t       s_data,
    input  wire cwda_pkg::cwda_q_status_t q_status,
    output logic                          push_valid,
    output cwda_pkg::cwda_prod_t          push_data
);

    localparam int CW  = cwda_pkg::CORDIC_W;
    localparam int CXW = CW - 14;   // rounded cosine before clamping, one spare bit for negation

    localparam logic signed [CXW-1:0] COS_HI = CXW'(32767);
    localparam logic signed [CXW-1:0] COS_LO = -CXW'(32768);

    typedef struct packed {
        logic [15:0]                       matrix_element;
        logic signed [cwda_pkg::SUM_W-1:0] prior_sum;
        logic                              last_element;
    } side_t;

    logic                 advance;

    logic [STAGES:0]      vld_reg;
    logic signed [CW-1:0] x_reg    [0:STAGES];
    logic signed [CW-1:0] y_reg    [0:STAGES];
    logic signed [CW-1:0] z_reg    [0:STAGES];
    logic                 neg_reg  [0:STAGES];
    side_t                side_reg [0:STAGES];

    logic                 rnd_vld_reg;
    logic signed [15:0]   cos_reg;
    side_t                rnd_side_reg;

    logic                 prod_vld_reg;
    cwda_pkg::cwda_prod_t prod_reg;

    logic signed [CW-1:0] z_in;
    logic signed [CW-1:0] z_fold;
    logic                 neg_fold;

    logic signed [CW-1:0]  x_round;
    logic signed [CW-16:0] c_trunc;
    logic signed [CXW-1:0] c_ext;
    logic signed [CXW-1:0] c_signed;
    logic signed [15:0]    c_clamped;

    // the whole pipe holds while the queue is full and a product waits
    assign advance    = !prod_vld_reg || !q_status.full;
    assign s_ready    = advance;
    assign push_valid = prod_vld_reg;
    assign push_data  = prod_reg;

    always_comb begin
        z_in     = $signed({2'b00, s_data.angle, 17'b0});
        z_fold   = z_in;
        neg_fold = 1'b0;
        if (z_in > cwda_pkg::HALF_PI_Q30) begin
            z_fold   = cwda_pkg::PI_Q30 - z_in;
            neg_fold = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg      <= '0;
            rnd_vld_reg  <= 1'b0;
            prod_vld_reg <= 1'b0;
        end else if (advance) begin
            vld_reg      <= {vld_reg[STAGES-1:0], s_valid};
            rnd_vld_reg  <= vld_reg[STAGES];
            prod_vld_reg <= rnd_vld_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            x_reg[0]                   <= cwda_pkg::CORDIC_GAIN_Q30;
            y_reg[0]                   <= '0;
            z_reg[0]                   <= z_fold;
            neg_reg[0]                 <= neg_fold;
            side_reg[0].matrix_element <= s_data.matrix_element;
            side_reg[0].prior_sum      <= s_data.prior_sum;
            side_reg[0].last_element   <= s_data.last_element;
        end
    end

    for (genvar g = 0; g < STAGES; g++) begin : g_cordic
        logic signed [CW-1:0] dx;
        logic signed [CW-1:0] dy;

        assign dx = y_reg[g] >>> g;
        assign dy = x_reg[g] >>> g;

        always_ff @(posedge aclk) begin
            if (advance) begin
                if (!z_reg[g][CW-1]) begin
                    x_reg[g+1] <= x_reg[g] - dx;
                    y_reg[g+1] <= y_reg[g] + dy;
                    z_reg[g+1] <= z_reg[g] - cwda_pkg::atan_q30(g);
                end else begin
                    x_reg[g+1] <= x_reg[g] + dx;
                    y_reg[g+1] <= y_reg[g] - dy;
                    z_reg[g+1] <= z_reg[g] + cwda_pkg::atan_q30(g);
                end
                neg_reg[g+1]  <= neg_reg[g];
                side_reg[g+1] <= side_reg[g];
            end
        end
    end

    // round Q2.30 to Q1.15, restore sign of the folded angle, clamp
    always_comb begin
        x_round  = x_reg[STAGES] + cwda_pkg::ROUND_BIAS;
        c_trunc  = x_round[CW-1:15];
        c_ext    = {c_trunc[CW-16], c_trunc};
        c_signed = neg_reg[STAGES] ? -c_ext : c_ext;
        if (c_signed > COS_HI) begin
            c_clamped = 16'sh7FFF;
        end else if (c_signed < COS_LO) begin
            c_clamped = 16'sh8000;
        end else begin
            c_clamped = c_signed[15:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            cos_reg      <= c_clamped;
            rnd_side_reg <= side_reg[STAGES];

            prod_reg.product      <= $signed({1'b0, rnd_side_reg.matrix_element}) * cos_reg;
            prod_reg.prior_sum    <= rnd_side_reg.prior_sum;
            prod_reg.last_element <= rnd_side_reg.last_element;
        end
    end

endmodule

`default_nettype wire

### rtl/cwda_back.sv
// Back end: saturating row accumulator, final add of the prior sum, result register.
`timescale 1ns / 1ps
`default_nettype none

module cwda_back (
    input  wire logic                     aclk,
    input  wire logic                     aresetn,
    input  wire cwda_pkg::cwda_prod_t     head_data,
    input  wire cwda_pkg::cwda_q_status_t q_status,
    output logic                          pop,
    output logic                          m_valid,
    input  wire logic                     m_ready,
    output cwda_pkg::cwda_out_t           m_data
);

    localparam int SW = cwda_pkg::SUM_W;
    localparam int PW = cwda_pkg::PROD_W;

    typedef struct packed {
        logic signed [SW-1:0] row_sum;
        logic                 clip;
        logic signed [SW-1:0] prior_sum;
    } fin_t;

    logic signed [SW-1:0] acc_reg;
    logic                 clip_reg;
    logic                 fin_vld_reg;
    fin_t                 fin_reg;
    logic                 m_vld_reg;
    cwda_pkg::cwda_out_t  m_data_reg;

    logic                 out_free;
    logic                 fin_free;
    logic                 fin_move;
    cwda_pkg::cwda_sat_t  acc_sum;
    cwda_pkg::cwda_sat_t  total;

    assign out_free = !m_vld_reg || m_ready;
    assign fin_move = fin_vld_reg && out_free;
    assign fin_free = !fin_vld_reg || out_free;
    // a row end needs room in the final-add stage; plain elements always go
    assign pop      = !q_status.empty && (!head_data.last_element || fin_free);

    assign acc_sum = cwda_pkg::sat48({acc_reg[SW-1], acc_reg}
                                     + {{(SW+1-PW){head_data.product[PW-1]}},
                                        head_data.product});
    assign total   = cwda_pkg::sat48({fin_reg.prior_sum[SW-1], fin_reg.prior_sum}
                                     + {fin_reg.row_sum[SW-1], fin_reg.row_sum});

    assign m_valid = m_vld_reg;
    assign m_data  = m_data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            acc_reg     <= '0;
            clip_reg    <= 1'b0;
            fin_vld_reg <= 1'b0;
            m_vld_reg   <= 1'b0;
        end else begin
            if (pop) begin
                if (head_data.last_element) begin
                    acc_reg  <= '0;
                    clip_reg <= 1'b0;
                end else begin
                    acc_reg  <= acc_sum.value;
                    clip_reg <= clip_reg | acc_sum.clipped;
                end
            end
            if (pop && head_data.last_element) begin
                fin_vld_reg <= 1'b1;
            end else if (fin_move) begin
                fin_vld_reg <= 1'b0;
            end
            if (fin_move) begin
                m_vld_reg <= 1'b1;
            end else if (m_ready) begin
                m_vld_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (pop && head_data.last_element) begin
            fin_reg.row_sum   <= acc_sum.value;
            fin_reg.clip      <= clip_reg | acc_sum.clipped;
            fin_reg.prior_sum <= head_data.prior_sum;
        end
        if (fin_move) begin
            m_data_reg.new_sum   <= total.value;
            m_data_reg.saturated <= fin_reg.clip | total.clipped;
        end
    end

endmodule

`default_nettype wire

### rtl/cosine_weighted_dot_accumulate.sv
// Cosine weighted dot accumulate: sum of matrix_element * cos(angle) per row, added to prior_sum.
// Throughput: one request per cycle while m_ready is high; the front pipe and the accumulator each
// take one per cycle; back-pressure on m_ready fills the queue and then holds the front pipe.
// Path: fold, one CORDIC stage per iteration, round, multiply, queue, accumulate, final add.
// Reset (aresetn low, synchronous) empties the pipe and queue and clears the row sum and clip flag;
// s_ready is high on the first cycle after reset.
`timescale 1ns / 1ps
`default_nettype none

module cosine_weighted_dot_accumulate #(
    parameter int COSINE_PRECISION_STAGES = cwda_pkg::COSINE_STAGES_DEFAULT
) (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                s_valid,
    output logic                     s_ready,
    input  wire cwda_pkg::cwda_in_t  s_data,
    output logic                     m_valid,
    input  wire logic                m_ready,
    output cwda_pkg::cwda_out_t      m_data
);

    logic                     push_valid;
    cwda_pkg::cwda_prod_t     push_data;
    logic                     pop;
    cwda_pkg::cwda_prod_t     head_data;
    cwda_pkg::cwda_q_status_t q_status;

    cwda_front #(
        .STAGES (COSINE_PRECISION_STAGES)
    ) u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_data     (s_data),
        .q_status   (q_status),
        .push_valid (push_valid),
        .push_data  (push_data)
    );

    cwda_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (push_valid),
        .push_data  (push_data),
        .pop        (pop),
        .head_data  (head_data),
        .status     (q_status)
    );

    cwda_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .head_data (head_data),
        .q_status  (q_status),
        .pop       (pop),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

endmodule

`default_nettype wire

### rtl/cwda_checker.sv
// Port-level checker for the cosine weighted dot accumulate block, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
`include "cosine_weighted_dot_accumulate_defines.svh"

module cwda_checker (
    input wire logic                aclk,
    input wire logic                aresetn,
    input wire logic                s_valid,
    input wire logic                s_ready,
    input wire cwda_pkg::cwda_in_t  s_data,
    input wire logic                m_valid,
    input wire logic                m_ready,
    input wire cwda_pkg::cwda_out_t m_data
);

    // row ends accepted but not yet delivered
    logic [7:0] pending_reg;
    logic [7:0] pending_next;
    logic       row_in;
    logic       row_out;

    assign row_in  = s_valid && s_ready && s_data.last_element;
    assign row_out = m_valid && m_ready;

    always_comb begin
        pending_next = pending_reg;
        if (row_in && !row_out) begin
            pending_next = pending_reg + 8'd1;
        end else if (row_out && !row_in) begin
            pending_next = pending_reg - 8'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pending_reg <= '0;
        end else begin
            pending_reg <= pending_next;
        end
    end

    `CWDA_ASSERT_NEXT(a_out_hold, aclk, aresetn, m_valid && !m_ready, m_valid && $stable(m_data), "result changed or dropped while stalled")
    `CWDA_ASSERT_IMPLIES(a_no_extra_result, aclk, aresetn, m_valid, pending_reg != 8'd0, "result without an accepted row end")
    `CWDA_ASSERT_AFTER_RESET(a_reset_out, aclk, aresetn, !m_valid, "m_valid high right after reset")
    `CWDA_ASSERT_AFTER_RESET(a_reset_ready, aclk, aresetn, s_ready, "s_ready low right after reset")

endmodule

bind cosine_weighted_dot_accumulate cwda_checker u_cwda_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_valid (s_valid),
    .s_ready (s_ready),
    .s_data  (s_data),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);

`default_nettype wire
